@@ rtl/core/rrs_pkg.sv @@
// shared widths, register codes, interface structs and state encodings
// for the reversing ramp setpoint unit; no dependencies
`default_nettype none
package rrs_pkg;

  localparam int POS_W   = 32;
  localparam int STEP_W  = 16;
  localparam int TIME_W  = 16;
  localparam int TMR_W   = TIME_W + 1;
  localparam int ELAP_W  = 8;
  localparam int PROD_W  = POS_W + STEP_W;
  localparam int CNT_W   = $clog2(PROD_W);

  localparam int NUM_REGS  = 5;
  localparam int CFG_DW    = (POS_W > 32) ? 64 : 32;
  localparam int ADDR_LSB  = (CFG_DW == 64) ? 3 : 2;
  localparam int CFG_AW    = $clog2(((NUM_REGS - 1) << ADDR_LSB) + 1);
  localparam int IDX_W     = CFG_AW - ADDR_LSB;

  typedef enum logic [IDX_W-1:0] {
    REG_LOW,
    REG_HIGH,
    REG_TOTAL,
    REG_INTERVAL,
    REG_DWELL
  } rrs_reg_t;

  typedef struct packed {
    logic              going_up;
    logic              dwelling;
    logic [STEP_W-1:0] step_idx;
  } rrs_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } rrs_ip_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rrs_ip_sts_t;

  typedef enum logic [2:0] {
    IP_IDLE,
    IP_MUL,
    IP_DIV,
    IP_FIN,
    IP_DONE
  } rrs_ip_st_t;

endpackage
`default_nettype wire

@@ rtl/core/rrs_step.sv @@
// trip state: arming, step timer, step index, dwell and direction
// depends on rrs_pkg
`default_nettype none
module rrs_step import rrs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic              restart,
  input  wire logic [ELAP_W-1:0] elapsed,
  input  wire logic [STEP_W-1:0] total,
  input  wire logic [TIME_W-1:0] interval,
  input  wire logic [TIME_W-1:0] dwell_len,
  output rrs_state_t             st
);

  logic              armed_r, armed_nxt;
  logic              up_r, up_nxt;
  logic              dwell_r, dwell_nxt;
  logic [STEP_W-1:0] idx_r, idx_nxt;
  logic [TMR_W-1:0]  tmr_r, tmr_nxt;

  logic [TMR_W:0]    sum;
  logic [TMR_W-1:0]  tmr_a;
  logic [STEP_W-1:0] idx_a;

  always_comb begin
    sum   = {1'b0, tmr_r} + (TMR_W + 1)'(elapsed);
    tmr_a = '0;
    if (armed_r) begin
      tmr_a = sum[TMR_W] ? '1 : sum[TMR_W-1:0];
    end
    armed_nxt = armed_r;
    up_nxt    = up_r;
    dwell_nxt = dwell_r;
    idx_nxt   = idx_r;
    tmr_nxt   = tmr_r;
    idx_a     = idx_r;
    if (restart) begin
      armed_nxt = 1'b0;
      up_nxt    = 1'b1;
      dwell_nxt = 1'b0;
      idx_nxt   = '0;
      tmr_nxt   = '0;
    end else if (accept) begin
      armed_nxt = 1'b1;
      tmr_nxt   = tmr_a;
      if (dwell_r) begin
        if (tmr_a >= {1'b0, dwell_len}) begin
          up_nxt    = ~up_r;
          idx_nxt   = '0;
          dwell_nxt = 1'b0;
          tmr_nxt   = '0;
        end
      end else if (tmr_a >= {1'b0, interval}) begin
        if (idx_r < total) begin
          idx_a   = idx_r + 1'b1;
          tmr_nxt = '0;
        end
        idx_nxt = idx_a;
        if (idx_a >= total) begin
          dwell_nxt = 1'b1;
          tmr_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      up_r    <= 1'b1;
      dwell_r <= 1'b0;
      idx_r   <= '0;
      tmr_r   <= '0;
    end else begin
      armed_r <= armed_nxt;
      up_r    <= up_nxt;
      dwell_r <= dwell_nxt;
      idx_r   <= idx_nxt;
      tmr_r   <= tmr_nxt;
    end
  end

  assign st.going_up = up_r;
  assign st.dwelling = dwell_r;
  assign st.step_idx = idx_r;

endmodule
`default_nettype wire

@@ rtl/core/rrs_interp.sv @@
// serial interpolation: shift-add multiply one step bit per cycle, then
// restoring divide one quotient bit per cycle unless total is zero; depends on rrs_pkg
`default_nettype none
module rrs_interp import rrs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rrs_ip_ctl_t       ctl,
  input  wire logic [POS_W-1:0]  low_pos,
  input  wire logic [POS_W-1:0]  high_pos,
  input  wire logic [STEP_W-1:0] total,
  input  wire rrs_state_t        st,
  output rrs_ip_sts_t            sts,
  output logic [POS_W-1:0]       result
);

  rrs_ip_st_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [POS_W-1:0]  start_r, mag_r, res_r;
  logic [STEP_W-1:0] mplr_r, div_r, rem_r;
  logic [PROD_W-1:0] acc_r;
  logic              neg_r, zero_r;

  logic              load, mul_en, div_en, fin_en;

  logic [POS_W-1:0]  start_v, end_v, mag_v;
  logic [POS_W:0]    diff, negd;
  logic [POS_W:0]    psum;
  logic [STEP_W:0]   trial;
  logic              qbit;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      IP_IDLE: begin
        if (ctl.start) begin
          state_nxt = IP_MUL;
          cnt_nxt   = CNT_W'(STEP_W - 1);
        end
      end
      IP_MUL: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = zero_r ? IP_FIN : IP_DIV;
          cnt_nxt   = CNT_W'(PROD_W - 1);
        end
      end
      IP_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = IP_FIN;
        end
      end
      IP_FIN: state_nxt = IP_DONE;
      IP_DONE: begin
        if (ctl.ack) begin
          state_nxt = IP_IDLE;
        end
      end
      default: state_nxt = IP_IDLE;
    endcase
  end

  always_comb begin
    load     = 1'b0;
    mul_en   = 1'b0;
    div_en   = 1'b0;
    fin_en   = 1'b0;
    sts.busy = 1'b1;
    sts.done = 1'b0;
    case (state_r)
      IP_IDLE: begin
        sts.busy = 1'b0;
        load     = ctl.start;
      end
      IP_MUL:  mul_en   = 1'b1;
      IP_DIV:  div_en   = 1'b1;
      IP_FIN:  fin_en   = 1'b1;
      IP_DONE: sts.done = 1'b1;
      default: sts.busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IP_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    start_v = st.going_up ? low_pos : high_pos;
    end_v   = st.going_up ? high_pos : low_pos;
    diff    = {end_v[POS_W-1], end_v} - {start_v[POS_W-1], start_v};
    negd    = -diff;
    mag_v   = diff[POS_W] ? negd[POS_W-1:0] : diff[POS_W-1:0];
    psum    = {1'b0, acc_r[PROD_W-1:STEP_W]} + (mplr_r[0] ? {1'b0, mag_r} : '0);
    trial   = {rem_r, acc_r[PROD_W-1]};
    qbit    = trial >= {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      start_r <= start_v;
      mag_r   <= mag_v;
      neg_r   <= diff[POS_W];
      zero_r  <= total == '0;
      mplr_r  <= st.step_idx;
      div_r   <= total;
      acc_r   <= '0;
      rem_r   <= '0;
    end
    if (mul_en) begin
      acc_r  <= {psum, acc_r[STEP_W-1:1]};
      mplr_r <= {1'b0, mplr_r[STEP_W-1:1]};
    end
    if (div_en) begin
      rem_r <= qbit ? STEP_W'(trial - {1'b0, div_r}) : trial[STEP_W-1:0];
      acc_r <= {acc_r[PROD_W-2:0], qbit};
    end
    if (fin_en) begin
      if (zero_r) begin
        res_r <= start_r;
      end else if (neg_r) begin
        res_r <= start_r - acc_r[POS_W-1:0];
      end else begin
        res_r <= start_r + acc_r[POS_W-1:0];
      end
    end
  end

  assign result = res_r;

endmodule
`default_nettype wire

@@ rtl/core/reversing_ramp_setpoint_unit.sv @@
// top level: config registers, item handshake, output register
// depends on rrs_pkg, rrs_step, rrs_interp
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_elapsed_ms
// out      output     out_valid / out_stall out_setpoint, out_step_now,
//                                          out_in_dwell, out_going_up
// cfg      input      apb write/read       low, high, total, interval, dwell
//
// items pass one at a time, a new one entering only after the output register
// takes the last result: the serial multiply runs one step bit per cycle, the
// divide one quotient bit per cycle unless total is zero, both through the
// single interpolation unit
// synchronous active-low reset restores the forward trip at step 0
// in_stall is high while an item is in the interpolation unit; the next item
// cannot enter until the output register takes the finished result
`default_nettype none
module reversing_ramp_setpoint_unit import rrs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ELAP_W-1:0] in_elapsed_ms,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [POS_W-1:0] out_setpoint,
  output logic [STEP_W-1:0]      out_step_now,
  output logic                   out_in_dwell,
  output logic                   out_going_up,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic [POS_W-1:0]  low_r, high_r;
  logic [STEP_W-1:0] total_r;
  logic [TIME_W-1:0] interval_r, dwell_r;

  logic              wr, restart, accept;
  rrs_reg_t          idx;
  rrs_state_t        st;
  rrs_ip_ctl_t       ip_ctl;
  rrs_ip_sts_t       ip_sts;
  logic [POS_W-1:0]  ip_res;

  logic              start_r;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  setpoint_r;
  logic [STEP_W-1:0] step_r;
  logic              dwell_flag_r, up_r;

  assign cfg_pready = 1'b1;
  assign idx        = rrs_reg_t'(cfg_paddr[CFG_AW-1:ADDR_LSB]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    restart    = 1'b0;
    cfg_prdata = '0;
    case (idx)
      REG_LOW: begin
        restart    = wr;
        cfg_prdata = CFG_DW'(low_r);
      end
      REG_HIGH: begin
        restart    = wr;
        cfg_prdata = CFG_DW'(high_r);
      end
      REG_TOTAL: begin
        restart    = wr;
        cfg_prdata = CFG_DW'(total_r);
      end
      REG_INTERVAL: begin
        restart    = wr;
        cfg_prdata = CFG_DW'(interval_r);
      end
      REG_DWELL: begin
        restart    = wr;
        cfg_prdata = CFG_DW'(dwell_r);
      end
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r      <= '0;
      high_r     <= '0;
      total_r    <= '0;
      interval_r <= '0;
      dwell_r    <= '0;
    end else if (wr) begin
      case (idx)
        REG_LOW:      low_r      <= cfg_pwdata[POS_W-1:0];
        REG_HIGH:     high_r     <= cfg_pwdata[POS_W-1:0];
        REG_TOTAL:    total_r    <= cfg_pwdata[STEP_W-1:0];
        REG_INTERVAL: interval_r <= cfg_pwdata[TIME_W-1:0];
        REG_DWELL:    dwell_r    <= cfg_pwdata[TIME_W-1:0];
        default:      low_r      <= low_r;
      endcase
    end
  end

  assign in_stall   = start_r || ip_sts.busy;
  assign accept     = in_valid && !in_stall;
  assign ip_ctl.start = start_r;
  assign ip_ctl.ack   = ip_sts.done && (!out_valid_r || !out_stall);
  assign out_valid_nxt = ip_ctl.ack || (out_valid_r && out_stall);

  rrs_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .restart   (restart),
    .elapsed   (in_elapsed_ms),
    .total     (total_r),
    .interval  (interval_r),
    .dwell_len (dwell_r),
    .st        (st)
  );

  rrs_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ip_ctl),
    .low_pos  (low_r),
    .high_pos (high_r),
    .total    (total_r),
    .st       (st),
    .sts      (ip_sts),
    .result   (ip_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r     <= accept;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ip_ctl.ack) begin
      setpoint_r   <= ip_res;
      step_r       <= st.step_idx;
      dwell_flag_r <= st.dwelling;
      up_r         <= st.going_up;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_setpoint = setpoint_r;
  assign out_step_now = step_r;
  assign out_in_dwell = dwell_flag_r;
  assign out_going_up = up_r;

  // an accepted item holds off the next one until the output register takes its result
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> in_stall)
    else $error("input taken while interpolation pending");

  // a finished result stays offered until the output register takes it
  assert property (@(posedge clk) disable iff (!rst_n)
    (ip_sts.done && !ip_ctl.ack) |=> ip_sts.done)
    else $error("interpolation result dropped");

  // the output register only fills from a finished interpolation
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ip_sts.done))
    else $error("output valid without result");

endmodule
`default_nettype wire
